FILE: hdl/imu_fp_pkg.sv
// Shared types, constants and helpers for the inertial-sensor frame parser.
package imu_fp_pkg;

  // Frame header and limits.
  localparam logic [7:0] SYNC0_BYTE  = 8'hFA;
  localparam logic [7:0] SYNC1_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC2_BYTE  = 8'h36;
  localparam logic [7:0] MAX_PAYLOAD = 8'd249;

  // Item ids and the only item size that carries three values.
  localparam logic [15:0] ID_EULER  = 16'h2030;
  localparam logic [15:0] ID_ACCEL  = 16'h4020;
  localparam logic [15:0] ID_GYRO   = 16'h8020;
  localparam logic [7:0]  ITEM_SIZE = 8'd12;

  // Value groups: three values each, nine in all.
  localparam int N_GROUPS  = 3;
  localparam int GROUP_LEN = 3;
  localparam int N_VALS    = N_GROUPS * GROUP_LEN;

  localparam logic [1:0] GRP_EULER = 2'd0;
  localparam logic [1:0] GRP_ACCEL = 2'd1;
  localparam logic [1:0] GRP_GYRO  = 2'd2;

  // Header tracking states.
  typedef enum logic [2:0] {
    HDR_HUNT    = 3'd0,
    HDR_SYNC1   = 3'd1,
    HDR_SYNC2   = 3'd2,
    HDR_LEN     = 3'd3,
    HDR_PAYLOAD = 3'd4
  } hdr_state_t;

  typedef logic [N_VALS-1:0][31:0] vals_t;

  // Control from the header tracker to the item walker.
  typedef struct packed {
    logic       frame_start;
    logic       walk_en;
    logic [7:0] frame_len;
    logic [7:0] pay_pos;
  } walk_ctl_t;

  // One result word.
  typedef struct packed {
    logic        frame_done;
    logic [31:0] byte_count;
    vals_t       vals;
  } res_t;

  // Maps an item id to its value group; hit is low for unknown ids.
  function automatic logic [2:0] group_of(input logic [15:0] id);
    logic [2:0] g;
    g = 3'b000;
    case (id)
      ID_EULER: g = {1'b1, GRP_EULER};
      ID_ACCEL: g = {1'b1, GRP_ACCEL};
      ID_GYRO:  g = {1'b1, GRP_GYRO};
      default:  g = 3'b000;
    endcase
    return g;
  endfunction

endpackage

FILE: hdl/imu_fp_walker.sv
// Payload item walker: tracks item boundaries and stages decoded values.
module imu_fp_walker
  import imu_fp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  walk_ctl_t  ctl,
  input  logic [7:0] rx_byte,
  output vals_t      staged
);

  logic [7:0]  item_start, item_start_next;
  logic [15:0] item_id, item_id_next;
  logic [7:0]  item_size, item_size_next;
  logic [GROUP_LEN-1:0][31:0] collector, collector_next;
  vals_t       staged_next;
  logic        coll_we;

  logic [7:0]  rel;
  logic [7:0]  rel_m3;
  logic [2:0]  grp;
  logic        hit;
  logic [1:0]  k;
  logic        walk_open;

  // Item decode for the byte at the current payload position.
  always_comb begin
    rel       = ctl.pay_pos - item_start;
    rel_m3    = rel - 8'd3;
    k         = rel_m3[3:2];
    grp       = group_of(item_id);
    hit       = grp[2] && (item_size == ITEM_SIZE);
    walk_open = ({1'b0, item_start} + 9'd2) < {1'b0, ctl.frame_len};

    item_start_next = item_start;
    item_id_next    = item_id;
    item_size_next  = item_size;
    collector_next  = collector;
    staged_next     = staged;
    coll_we         = 1'b0;

    if (ctl.frame_start) begin
      item_start_next = 8'd0;
      item_id_next    = 16'd0;
      item_size_next  = 8'd0;
    end else if (ctl.walk_en && walk_open) begin
      if (rel == 8'd0) begin
        item_id_next = {rx_byte, 8'h00};
      end else if (rel == 8'd1) begin
        item_id_next = {item_id[15:8], rx_byte};
      end else if (rel == 8'd2) begin
        item_size_next = rx_byte;
        // An item that overruns the frame ends the walk.
        if (({2'b00, item_start} + 10'd3 + {2'b00, rx_byte}) > {2'b00, ctl.frame_len}) begin
          item_start_next = ctl.frame_len;
        end else if (rx_byte == 8'd0) begin
          item_start_next = item_start + 8'd3;
        end
      end else begin
        // Content bytes shift into the value being collected.
        if (hit && (k < 2'(GROUP_LEN))) begin
          coll_we = 1'b1;
          collector_next[k] = {collector[k][23:0], rx_byte};
        end
        // Last content byte: stage the group and move to the next item.
        if ({1'b0, rel} == ({1'b0, item_size} + 9'd2)) begin
          for (int g = 0; g < N_GROUPS; g++) begin
            if (hit && (grp[1:0] == 2'(g))) begin
              for (int v = 0; v < GROUP_LEN; v++) begin
                staged_next[g*GROUP_LEN + v] = collector_next[v];
              end
            end
          end
          item_start_next = item_start + 8'd3 + item_size;
        end
      end
    end
  end

  // Item tracking and staged values.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_start <= 8'd0;
      item_id    <= 16'd0;
      item_size  <= 8'd0;
      staged     <= '0;
    end else begin
      item_start <= item_start_next;
      item_id    <= item_id_next;
      item_size  <= item_size_next;
      staged     <= staged_next;
    end
  end

  // The collector holds only content bytes and needs no reset.
  always_ff @(posedge clk) begin
    if (coll_we) begin
      collector <= collector_next;
    end
  end

endmodule

FILE: hdl/imu_fp_outbuf.sv
// Two-word output buffer: a result register with a skid register behind it.
module imu_fp_outbuf
  import imu_fp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop   = out_valid && out_ready;
  assign ready = !skid_valid;

  // Control: a push only arrives while the skid register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end else if (pop && skid_valid) begin
      out_res <= skid_res;
    end
  end

endmodule

FILE: hdl/imu_frame_parser_core.sv
// Top level of the inertial-sensor frame parser: header tracking and publishing.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  input   | in        | in_valid / in_ready  | rx_byte
//  output  | out       | out_valid / out_ready| frame_done, byte_count, nine values
//
// Each accepted byte updates the parser state in the cycle it is taken, and its result
// word is registered into the output buffer; one byte per cycle sustained while the skid register is empty.
// Reset (rst, synchronous) returns the parser to header hunting with all values zero.
// A stalled output keeps one extra word in a skid register; in_ready drops only
// while that register is occupied, and is low during reset.
module imu_frame_parser_core
  import imu_fp_pkg::*;
#(
  parameter logic [7:0] MAX_LEN = MAX_PAYLOAD
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_done,
  output logic [31:0] byte_count,
  output logic [31:0] roll_bits,
  output logic [31:0] pitch_bits,
  output logic [31:0] yaw_bits,
  output logic [31:0] accel_x_bits,
  output logic [31:0] accel_y_bits,
  output logic [31:0] accel_z_bits,
  output logic [31:0] gyro_x_bits,
  output logic [31:0] gyro_y_bits,
  output logic [31:0] gyro_z_bits
);

  hdr_state_t  hdr, hdr_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  pay_pos, pay_pos_next;
  logic [31:0] total, total_next;
  vals_t       published, published_next;
  vals_t       staged;
  walk_ctl_t   ctl;
  logic        done;
  logic        acc;
  logic        buf_ready;
  res_t        res, out_res;

  assign in_ready = buf_ready && !rst;
  assign acc      = in_valid && in_ready;

  // Header tracking and payload position.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr       <= HDR_HUNT;
      frame_len <= 8'd0;
      pay_pos   <= 8'd0;
      total     <= 32'd0;
      published <= '0;
    end else begin
      hdr       <= hdr_next;
      frame_len <= frame_len_next;
      pay_pos   <= pay_pos_next;
      total     <= total_next;
      published <= published_next;
    end
  end

  // Next state, walker control and the result word for an accepted byte.
  always_comb begin
    hdr_next        = hdr;
    frame_len_next  = frame_len;
    pay_pos_next    = pay_pos;
    total_next      = total;
    done            = 1'b0;
    ctl.frame_start = 1'b0;
    ctl.walk_en     = 1'b0;
    ctl.frame_len   = frame_len;
    ctl.pay_pos     = pay_pos;

    if (acc) begin
      total_next = total + 32'd1;
      case (hdr)
        HDR_HUNT: begin
          if (rx_byte == SYNC0_BYTE) hdr_next = HDR_SYNC1;
        end
        HDR_SYNC1: begin
          hdr_next = (rx_byte == SYNC1_BYTE) ? HDR_SYNC2 : HDR_HUNT;
        end
        HDR_SYNC2: begin
          hdr_next = (rx_byte == SYNC2_BYTE) ? HDR_LEN : HDR_HUNT;
        end
        HDR_LEN: begin
          frame_len_next  = rx_byte;
          pay_pos_next    = 8'd0;
          ctl.frame_start = 1'b1;
          hdr_next = (rx_byte inside {[8'd1:MAX_LEN]}) ? HDR_PAYLOAD : HDR_HUNT;
        end
        HDR_PAYLOAD: begin
          if (pay_pos >= frame_len) begin
            // Checksum byte: frame ends and staged values are published.
            done     = 1'b1;
            hdr_next = HDR_HUNT;
          end else begin
            ctl.walk_en  = 1'b1;
            pay_pos_next = pay_pos + 8'd1;
          end
        end
        default: begin
          hdr_next = HDR_HUNT;
        end
      endcase
    end

    published_next = done ? staged : published;
    res.frame_done = done;
    res.byte_count = total_next;
    res.vals       = published_next;
  end

  imu_fp_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rx_byte (rx_byte),
    .staged  (staged)
  );

  imu_fp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_res  (res),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result word fields.
  assign frame_done   = out_res.frame_done;
  assign byte_count   = out_res.byte_count;
  assign roll_bits    = out_res.vals[0];
  assign pitch_bits   = out_res.vals[1];
  assign yaw_bits     = out_res.vals[2];
  assign accel_x_bits = out_res.vals[3];
  assign accel_y_bits = out_res.vals[4];
  assign accel_z_bits = out_res.vals[5];
  assign gyro_x_bits  = out_res.vals[6];
  assign gyro_y_bits  = out_res.vals[7];
  assign gyro_z_bits  = out_res.vals[8];

  // A full buffer always has a word on the output.
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !buf_ready |-> out_valid)
    else $error("skid register holds a word while the output is empty");

  // The payload position never runs past the frame length.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (hdr == HDR_PAYLOAD) |-> (pay_pos <= frame_len))
    else $error("payload position beyond frame length");

  // The checksum byte ends the frame and returns to hunting.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (acc && hdr == HDR_PAYLOAD && pay_pos >= frame_len) |=> (hdr == HDR_HUNT))
    else $error("frame did not end on the checksum byte");

  // Each accepted byte advances the byte count by one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    acc |=> (total == $past(total) + 32'd1))
    else $error("byte count did not advance on an accepted byte");

endmodule

FILE: tb/tb_imu_frame_parser_core.sv
// Self-checking testbench for the inertial-sensor frame parser core.
module tb_imu_frame_parser_core
  import imu_fp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stall modes.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_SPARSE  = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_done;
  logic [31:0] byte_count;
  logic [31:0] roll_bits, pitch_bits, yaw_bits;
  logic [31:0] accel_x_bits, accel_y_bits, accel_z_bits;
  logic [31:0] gyro_x_bits, gyro_y_bits, gyro_z_bits;

  imu_frame_parser_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_done(frame_done), .byte_count(byte_count),
    .roll_bits(roll_bits), .pitch_bits(pitch_bits), .yaw_bits(yaw_bits),
    .accel_x_bits(accel_x_bits), .accel_y_bits(accel_y_bits), .accel_z_bits(accel_z_bits),
    .gyro_x_bits(gyro_x_bits), .gyro_y_bits(gyro_y_bits), .gyro_z_bits(gyro_z_bits)
  );

  always #5 clk = ~clk;

  // Byte stream to send, payload under construction, and predicted result words.
  logic [7:0] rx_stream[$];
  logic [7:0] frame_body[$];
  res_t       expected_words[$];

  int errors   = 0;
  int word_idx = 0;

  string val_names[N_VALS] = '{"roll_bits", "pitch_bits", "yaw_bits",
                               "accel_x_bits", "accel_y_bits", "accel_z_bits",
                               "gyro_x_bits", "gyro_y_bits", "gyro_z_bits"};

  // Parser state mirrored by the predictor.
  hdr_state_t  parse_st  = HDR_HUNT;
  logic [7:0]  frm_len   = 8'd0;
  logic [7:0]  pay_pos   = 8'd0;
  logic [7:0]  item_base = 8'd0;
  logic [7:0]  item_sz   = 8'd0;
  logic [15:0] item_tag  = 16'd0;
  logic [31:0] collect[3] = '{32'd0, 32'd0, 32'd0};
  vals_t       staged    = '0;
  vals_t       published = '0;
  logic [31:0] rx_total  = 32'd0;

  // Advances the mirrored parser by one received byte and returns its result word.
  function automatic res_t parse_byte(input logic [7:0] b);
    res_t        r;
    logic [31:0] rel;
    logic [31:0] k;
    int          grp;
    rx_total = rx_total + 32'd1;
    r.frame_done = 1'b0;
    case (parse_st)
      HDR_HUNT: begin
        if (b == SYNC0_BYTE) parse_st = HDR_SYNC1;
      end
      HDR_SYNC1: parse_st = (b == SYNC1_BYTE) ? HDR_SYNC2 : HDR_HUNT;
      HDR_SYNC2: parse_st = (b == SYNC2_BYTE) ? HDR_LEN : HDR_HUNT;
      HDR_LEN: begin
        frm_len   = b;
        pay_pos   = 8'd0;
        item_base = 8'd0;
        item_tag  = 16'd0;
        item_sz   = 8'd0;
        parse_st  = (b >= 8'd1 && b <= MAX_PAYLOAD) ? HDR_PAYLOAD : HDR_HUNT;
      end
      HDR_PAYLOAD: begin
        if (pay_pos >= frm_len) begin
          // Checksum byte: publish whatever was staged.
          published    = staged;
          r.frame_done = 1'b1;
          parse_st     = HDR_HUNT;
        end else begin
          // Item walk; stops once fewer than three bytes remain for a header.
          if (int'(item_base) + 2 < int'(frm_len)) begin
            rel = 32'(pay_pos) - 32'(item_base);
            if (rel == 32'd0) begin
              item_tag = {b, 8'h00};
            end else if (rel == 32'd1) begin
              item_tag[7:0] = b;
            end else if (rel == 32'd2) begin
              item_sz = b;
              if (int'(item_base) + 3 + int'(b) > int'(frm_len)) begin
                item_base = frm_len;
              end else if (b == 8'd0) begin
                item_base = item_base + 8'd3;
              end
            end else begin
              grp = -1;
              if (item_sz == ITEM_SIZE) begin
                case (item_tag)
                  ID_EULER: grp = 0;
                  ID_ACCEL: grp = 3;
                  ID_GYRO:  grp = 6;
                  default:  grp = -1;
                endcase
              end
              if (grp >= 0) begin
                k = ((rel - 32'd3) >> 2) & 32'd3;
                if (k < 32'd3) collect[k] = {collect[k][23:0], b};
              end
              if (rel == 32'd2 + 32'(item_sz)) begin
                if (grp >= 0) begin
                  for (int j = 0; j < GROUP_LEN; j++) staged[grp + j] = collect[j];
                end
                item_base = item_base + 8'd3 + item_sz;
              end
            end
          end
          pay_pos = pay_pos + 8'd1;
        end
      end
      default: parse_st = HDR_HUNT;
    endcase
    r.byte_count = rx_total;
    r.vals       = published;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch on word %0d: %s got %h expected %h", word_idx, what, seen, want);
  endtask

  // Stream building helpers.
  task automatic put(input logic [7:0] b);
    rx_stream.push_back(b);
  endtask

  task automatic put_header(input logic [7:0] len);
    put(SYNC0_BYTE);
    put(SYNC1_BYTE);
    put(SYNC2_BYTE);
    put(len);
  endtask

  task automatic add_item(input logic [15:0] id, input int size);
    frame_body.push_back(id[15:8]);
    frame_body.push_back(id[7:0]);
    frame_body.push_back(8'(size));
    for (int i = 0; i < size; i++) frame_body.push_back(8'($urandom));
  endtask

  // Sends a header with the given length, that many payload bytes and a checksum.
  task automatic send_frame(input int len);
    put_header(8'(len));
    for (int i = 0; i < len; i++)
      put((i < frame_body.size()) ? frame_body[i] : 8'($urandom));
    put(8'($urandom));
    frame_body.delete();
  endtask

  function automatic logic [15:0] pick_known_id();
    case ($urandom_range(0, 2))
      0:       return ID_EULER;
      1:       return ID_ACCEL;
      default: return ID_GYRO;
    endcase
  endfunction

  // Well-formed frame with random items, sometimes padded or cut short.
  task automatic random_frame();
    int n;
    int len;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_item(pick_known_id(), ITEM_SIZE);
        6:       add_item(pick_known_id(), $urandom_range(0, 20));
        7:       add_item(16'($urandom), $urandom_range(0, 16));
        8:       add_item(pick_known_id() ^ (16'h1 << $urandom_range(0, 15)), ITEM_SIZE);
        default: add_item(16'($urandom), 0);
      endcase
    end
    len = frame_body.size();
    case ($urandom_range(0, 9))
      6, 7:    len = len + $urandom_range(1, 2);
      8, 9: begin
        if (len > 1) len = $urandom_range(1, len - 1);
      end
      default: ;
    endcase
    if (len < 1) len = 1;
    send_frame(len);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (rx_stream.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte  <= rx_stream.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall mode is picked anew whenever its countdown runs out.
  int         stall_mode = RX_ALWAYS;
  int         stall_left = 0;
  logic [7:0] stall_pat  = 8'h01;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(RX_ALWAYS, RX_SPARSE);
      stall_pat  <= 8'($urandom) | 8'h01;
      stall_left <= $urandom_range(16, 96);
      out_ready  <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_PATTERN: begin
          out_ready <= stall_pat[0];
          stall_pat <= {stall_pat[0], stall_pat[7:1]};
        end
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predict on every accepted byte, check every accepted result word.
  res_t  want;
  vals_t seen_vals;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_words.push_back(parse_byte(rx_byte));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word, byte_count", byte_count, 32'd0);
        end else begin
          want = expected_words.pop_front();
          seen_vals[0] = roll_bits;
          seen_vals[1] = pitch_bits;
          seen_vals[2] = yaw_bits;
          seen_vals[3] = accel_x_bits;
          seen_vals[4] = accel_y_bits;
          seen_vals[5] = accel_z_bits;
          seen_vals[6] = gyro_x_bits;
          seen_vals[7] = gyro_y_bits;
          seen_vals[8] = gyro_z_bits;
          if (frame_done !== want.frame_done)
            report("frame_done", 32'(frame_done), 32'(want.frame_done));
          if (byte_count !== want.byte_count)
            report("byte_count", byte_count, want.byte_count);
          for (int vi = 0; vi < N_VALS; vi++) begin
            if (seen_vals[vi] !== want.vals[vi])
              report(val_names[vi], seen_vals[vi], want.vals[vi]);
          end
        end
        word_idx++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0] bad;
    // Directed: a bad header byte is not taken as a new first sync byte.
    put(SYNC0_BYTE);
    put(SYNC0_BYTE);
    put(SYNC1_BYTE);
    put(SYNC2_BYTE);
    // Directed: zero length and a length just past the limit.
    put_header(8'd0);
    put_header(MAX_PAYLOAD + 8'd1);
    // Directed: shortest frame with a single zero payload byte.
    frame_body.push_back(8'h00);
    send_frame(1);
    // Directed: one frame carrying Euler angles.
    add_item(ID_EULER, ITEM_SIZE);
    send_frame(15);

    // Random mix, mostly well-formed frames.
    while (rx_stream.size() < 150) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: random_frame();
        7: begin
          // Line noise biased toward sync values, ending on a byte that resets the hunt.
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 5))
              0:       put(SYNC0_BYTE);
              1:       put(SYNC1_BYTE);
              2:       put(SYNC2_BYTE);
              default: put(8'($urandom));
            endcase
          end
          put(8'h00);
        end
        8: begin
          // Header broken after one or two good bytes.
          put(SYNC0_BYTE);
          if ($urandom_range(0, 1) == 0) begin
            put(SYNC1_BYTE);
            bad = 8'($urandom);
            if (bad == SYNC2_BYTE) bad = bad ^ 8'h01;
          end else begin
            bad = 8'($urandom);
            if (bad == SYNC1_BYTE) bad = bad ^ 8'h01;
          end
          put(bad);
        end
        default: begin
          // Out-of-range length byte.
          if ($urandom_range(0, 2) == 0) put_header(8'd0);
          else put_header(8'($urandom_range(int'(MAX_PAYLOAD) + 1, 255)));
        end
      endcase
    end

    // One frame of maximum length: sixteen full items and a short unknown one.
    repeat (16) begin
      if ($urandom_range(0, 3) == 0) add_item(16'($urandom), ITEM_SIZE);
      else add_item(pick_known_id(), ITEM_SIZE);
    end
    add_item(16'h0001, 6);
    send_frame(int'(MAX_PAYLOAD));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0 && expected_words.size() == 0) begin
      $display("imu_frame_parser_core regression: pass");
    end else begin
      $display("imu_frame_parser_core regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("imu_frame_parser_core regression: fail");
    $finish;
  end

endmodule
